// ===== src/pttr_pkg.sv =====
// pan/tilt tracker package: field widths, shared types and reset values.
// no dependencies.
`timescale 1ns / 1ps

package pttr_pkg;

    localparam int COORD_W = 12;
    localparam int SUM_W   = 13;
    localparam int AREA_W  = 24;
    localparam int ANGLE_W = 8;
    localparam int DUTY_W  = 20;

    localparam int PWM_RATE_HZ_DEF = 50;
    localparam int DUTY_BASE       = 500;
    localparam int DUTY_SPAN       = 1900;
    localparam int ANGLE_MAX       = 180;
    localparam int ANGLE_CODES     = 2 ** ANGLE_W;

    localparam logic [ANGLE_W-1:0] ANGLE_TOP  = 8'd180;
    localparam logic [ANGLE_W-1:0] ANGLE_HOME = 8'd90;

    localparam logic [COORD_W-1:0] CENTRE_X_RESET = 12'd320;
    localparam logic [COORD_W-1:0] CENTRE_Y_RESET = 12'd240;

    typedef enum logic {
        REG_CENTRE_X = 1'b0,
        REG_CENTRE_Y = 1'b1
    } reg_index_t;

    typedef enum logic [1:0] {
        SIDE_NONE = 2'd0,
        SIDE_POS  = 2'd1,
        SIDE_NEG  = 2'd2
    } side_t;

    typedef struct packed {
        side_t side;
        logic  step2;
    } axis_t;

    typedef struct packed {
        logic [COORD_W-1:0] bottom;
        logic [COORD_W-1:0] right;
        logic [COORD_W-1:0] top;
        logic [COORD_W-1:0] left;
        logic               last;
    } box_t;

    typedef struct packed {
        logic [AREA_W-1:0] area;
        logic [SUM_W-1:0]  x_sum;
        logic [SUM_W-1:0]  y_sum;
        logic              last;
    } meas_t;

    typedef struct packed {
        logic [ANGLE_W-1:0] pan_angle;
        logic [ANGLE_W-1:0] tilt_angle;
        logic               pan_written;
        logic               tilt_written;
    } servo_res_t;

endpackage

// ===== src/pan_tilt_face_tracker_step.sv =====
// channel   direction  payload
// s_        in         face box edges, tlast marks the last box of a frame
// m_        out        servo angles and duty values, one per frame
// cfg_      in         centre_x (index 0), centre_y (index 1)
//
// one box accepted per cycle unless a stall holds the input; after its last box
// is accepted, a frame result passes the area multiply, the band decision and
// servo step, and the duty lookup, each registered. synchronous active-low reset
// puts both servos at 90 degrees and centres at 320 and 240. stalls on m_ travel
// back stage by stage; empty stages keep accepting. cfg writes are always taken.
// top level, depends on pttr_pkg, pttr_box_stage, pttr_servo_stage,
// pttr_out_stage.
`timescale 1ns / 1ps

module pan_tilt_face_tracker_step #(
    parameter int PWM_RATE_HZ = pttr_pkg::PWM_RATE_HZ_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // box_left, box_top, box_right, box_bottom
    input  logic        s_tlast,   // last_box
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // pan_angle, tilt_angle, pan_duty, tilt_duty
    output logic [1:0]  m_tuser,   // pan_written, tilt_written
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [11:0] cfg_data
);

    logic [pttr_pkg::COORD_W-1:0] centre_x_reg;
    logic [pttr_pkg::COORD_W-1:0] centre_y_reg;
    pttr_pkg::box_t               in_box;
    logic                         meas_valid;
    logic                         meas_ready;
    pttr_pkg::meas_t              meas;
    logic                         res_valid;
    logic                         res_ready;
    pttr_pkg::servo_res_t         res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            centre_x_reg <= pttr_pkg::CENTRE_X_RESET;
            centre_y_reg <= pttr_pkg::CENTRE_Y_RESET;
        end else if (cfg_valid) begin
            case (pttr_pkg::reg_index_t'(cfg_index))
                pttr_pkg::REG_CENTRE_X: centre_x_reg <= cfg_data;
                pttr_pkg::REG_CENTRE_Y: centre_y_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign in_box.left   = s_tdata[11:0];
    assign in_box.top    = s_tdata[23:12];
    assign in_box.right  = s_tdata[35:24];
    assign in_box.bottom = s_tdata[47:36];
    assign in_box.last   = s_tlast;

    pttr_box_stage u_box (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_box     (in_box),
        .meas_valid (meas_valid),
        .meas_ready (meas_ready),
        .meas       (meas)
    );

    pttr_servo_stage u_servo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .meas_valid (meas_valid),
        .meas_ready (meas_ready),
        .meas       (meas),
        .centre_x   (centre_x_reg),
        .centre_y   (centre_y_reg),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    pttr_out_stage #(
        .PWM_RATE_HZ (PWM_RATE_HZ)
    ) u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// ===== src/pttr_box_stage.sv =====
// box stage: input register, then box area and doubled box centres
// registered. depends on pttr_pkg.
`timescale 1ns / 1ps

module pttr_box_stage (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  pttr_pkg::box_t                 in_box,
    output logic                           meas_valid,
    input  logic                           meas_ready,
    output pttr_pkg::meas_t                meas
);

    logic            box_valid_reg;
    logic            box_valid_next;
    pttr_pkg::box_t  box_reg;
    logic            meas_valid_reg;
    logic            meas_valid_next;
    pttr_pkg::meas_t meas_reg;
    pttr_pkg::meas_t meas_next;
    logic            meas_open;
    logic            box_open;
    logic [pttr_pkg::COORD_W-1:0] width;
    logic [pttr_pkg::COORD_W-1:0] height;

    assign meas_open = !meas_valid_reg || meas_ready;
    assign box_open  = !box_valid_reg || meas_open;
    assign in_ready  = box_open;

    assign width  = (box_reg.right >= box_reg.left) ? box_reg.right - box_reg.left : '0;
    assign height = (box_reg.bottom >= box_reg.top) ? box_reg.bottom - box_reg.top : '0;

    always_comb begin
        meas_next.area  = width * height;
        meas_next.x_sum = {1'b0, box_reg.left} + {1'b0, box_reg.right};
        meas_next.y_sum = {1'b0, box_reg.top} + {1'b0, box_reg.bottom};
        meas_next.last  = box_reg.last;
    end

    always_comb begin
        box_valid_next = box_valid_reg;
        if (box_open) begin
            box_valid_next = in_valid;
        end
        meas_valid_next = meas_valid_reg;
        if (meas_open) begin
            meas_valid_next = box_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            box_valid_reg  <= 1'b0;
            meas_valid_reg <= 1'b0;
        end else begin
            box_valid_reg  <= box_valid_next;
            meas_valid_reg <= meas_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (box_open && in_valid) begin
            box_reg <= in_box;
        end
        if (meas_open && box_valid_reg) begin
            meas_reg <= meas_next;
        end
    end

    assign meas_valid = meas_valid_reg;
    assign meas       = meas_reg;

endmodule

// ===== src/pttr_servo_stage.sv =====
// servo stage: keeps the largest box of the frame, decides the dead band
// and steps the pan and tilt angles on the last box. depends on pttr_pkg.
`timescale 1ns / 1ps

module pttr_servo_stage (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    meas_valid,
    output logic                    meas_ready,
    input  pttr_pkg::meas_t         meas,
    input  logic [pttr_pkg::COORD_W-1:0] centre_x,
    input  logic [pttr_pkg::COORD_W-1:0] centre_y,
    output logic                    res_valid,
    input  logic                    res_ready,
    output pttr_pkg::servo_res_t    res
);

    logic [pttr_pkg::AREA_W-1:0]  best_area_reg;
    logic [pttr_pkg::SUM_W-1:0]   best_x_sum_reg;
    logic [pttr_pkg::SUM_W-1:0]   best_y_sum_reg;
    logic                         frame_open_reg;
    logic                         frame_open_next;
    logic [pttr_pkg::ANGLE_W-1:0] pan_deg_reg;
    logic [pttr_pkg::ANGLE_W-1:0] pan_deg_next;
    logic [pttr_pkg::ANGLE_W-1:0] tilt_deg_reg;
    logic [pttr_pkg::ANGLE_W-1:0] tilt_deg_next;
    logic                         res_valid_reg;
    logic                         res_valid_next;
    pttr_pkg::servo_res_t         res_reg;
    pttr_pkg::servo_res_t         res_next;
    logic                         take;
    logic                         keep_new;
    logic [pttr_pkg::SUM_W-1:0]   sel_x_sum;
    logic [pttr_pkg::SUM_W-1:0]   sel_y_sum;
    pttr_pkg::axis_t              sel_pan;
    pttr_pkg::axis_t              sel_tilt;

    function automatic pttr_pkg::axis_t axis_of(input logic [pttr_pkg::SUM_W-1:0] sum,
                                                input logic [pttr_pkg::COORD_W-1:0] centre);
        logic signed [17:0] d;
        logic signed [17:0] five_d;
        logic signed [17:0] two_c;
        logic signed [17:0] abs_d;
        logic signed [17:0] c_s;
        pttr_pkg::axis_t    a;
        d      = $signed({5'b0, sum}) - $signed({5'b0, centre, 1'b0});
        five_d = (d <<< 2) + d;
        two_c  = $signed({5'b0, centre, 1'b0});
        abs_d  = d[17] ? -d : d;
        c_s    = $signed({6'b0, centre});
        a.step2 = !(abs_d < c_s);
        if (five_d > two_c) begin
            a.side = pttr_pkg::SIDE_POS;
        end else if (-five_d > two_c) begin
            a.side = pttr_pkg::SIDE_NEG;
        end else begin
            a.side = pttr_pkg::SIDE_NONE;
        end
        return a;
    endfunction

    function automatic logic [pttr_pkg::ANGLE_W-1:0] move(
        input logic [pttr_pkg::ANGLE_W-1:0] ang,
        input logic                         up,
        input logic                         down,
        input logic                         step2);
        logic [pttr_pkg::ANGLE_W-1:0] st;
        logic [pttr_pkg::ANGLE_W-1:0] r;
        st = step2 ? 8'd2 : 8'd1;
        r  = ang;
        if (up && (ang < pttr_pkg::ANGLE_TOP - st)) begin
            r = ang + st;
        end else if (down && (ang > st)) begin
            r = ang - st;
        end
        return r;
    endfunction

    assign meas_ready = !meas_valid || !meas.last || res_ready;
    assign take       = meas_valid && meas_ready;
    assign keep_new   = !frame_open_reg || (meas.area > best_area_reg);
    assign sel_x_sum  = keep_new ? meas.x_sum : best_x_sum_reg;
    assign sel_y_sum  = keep_new ? meas.y_sum : best_y_sum_reg;
    assign sel_pan    = axis_of(sel_x_sum, centre_x);
    assign sel_tilt   = axis_of(sel_y_sum, centre_y);

    always_comb begin
        res_next.pan_angle    = move(pan_deg_reg, sel_pan.side == pttr_pkg::SIDE_NEG,
                                     sel_pan.side == pttr_pkg::SIDE_POS, sel_pan.step2);
        res_next.tilt_angle   = move(tilt_deg_reg, sel_tilt.side == pttr_pkg::SIDE_POS,
                                     sel_tilt.side == pttr_pkg::SIDE_NEG, sel_tilt.step2);
        res_next.pan_written  = sel_pan.side != pttr_pkg::SIDE_NONE;
        res_next.tilt_written = sel_tilt.side != pttr_pkg::SIDE_NONE;
    end

    always_comb begin
        frame_open_next = frame_open_reg;
        pan_deg_next    = pan_deg_reg;
        tilt_deg_next   = tilt_deg_reg;
        res_valid_next  = res_valid_reg && !res_ready;
        if (take) begin
            frame_open_next = !meas.last;
            if (meas.last) begin
                pan_deg_next   = res_next.pan_angle;
                tilt_deg_next  = res_next.tilt_angle;
                res_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_open_reg <= 1'b0;
            pan_deg_reg    <= pttr_pkg::ANGLE_HOME;
            tilt_deg_reg   <= pttr_pkg::ANGLE_HOME;
            res_valid_reg  <= 1'b0;
        end else begin
            frame_open_reg <= frame_open_next;
            pan_deg_reg    <= pan_deg_next;
            tilt_deg_reg   <= tilt_deg_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take && keep_new) begin
            best_area_reg  <= meas.area;
            best_x_sum_reg <= meas.x_sum;
            best_y_sum_reg <= meas.y_sum;
        end
        if (take && meas.last) begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ===== src/pttr_out_stage.sv =====
// output stage: looks up pwm duty for both angles and holds the result
// transfer. depends on pttr_pkg.
`timescale 1ns / 1ps

module pttr_out_stage #(
    parameter int PWM_RATE_HZ = pttr_pkg::PWM_RATE_HZ_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 res_valid,
    output logic                 res_ready,
    input  pttr_pkg::servo_res_t res,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [55:0]          m_tdata,
    output logic [1:0]           m_tuser
);

    logic [pttr_pkg::DUTY_W-1:0] duty_tab [0:pttr_pkg::ANGLE_CODES-1];

    logic        m_tvalid_reg;
    logic        m_tvalid_next;
    logic [55:0] m_tdata_reg;
    logic [55:0] m_tdata_next;
    logic [1:0]  m_tuser_reg;

    // constant duty per angle code
    for (genvar a = 0; a < pttr_pkg::ANGLE_CODES; a++) begin : g_duty
        localparam logic [31:0] DUTY_V = pttr_pkg::DUTY_BASE * PWM_RATE_HZ
                                         + (pttr_pkg::DUTY_SPAN * PWM_RATE_HZ * a)
                                           / pttr_pkg::ANGLE_MAX;
        assign duty_tab[a] = DUTY_V[pttr_pkg::DUTY_W-1:0];
    end

    assign res_ready = !m_tvalid_reg || m_tready;

    assign m_tdata_next = {duty_tab[res.tilt_angle], duty_tab[res.pan_angle],
                           res.tilt_angle, res.pan_angle};

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (res_ready) begin
            m_tvalid_next = res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= {res.tilt_written, res.pan_written};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
